FILE: rtl/core/egbr_pkg.sv
// ----------------------------------------------------------------------------
// egbr_pkg
// shared types and constants of the exp-golomb bit reader
// ----------------------------------------------------------------------------
package egbr_pkg;

  // default byte store depth
  localparam int StoreBytesDef = 256;

  localparam int ByteW  = 8;
  localparam int PosW   = 12;  // bit position, saturates at all ones
  localparam int ValueW = 33;  // result value, two's complement
  localparam int CntW   = 6;   // bit count and prefix count, up to 32

  localparam logic [CntW-1:0] PrefixLimit = CntW'(32);
  localparam logic [CntW-1:0] MaxBits     = CntW'(32);

  // item kinds
  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_PUSH  = 3'd1,
    KIND_BITS  = 3'd2,
    KIND_UE    = 3'd3,
    KIND_SE    = 3'd4,
    KIND_SKIP  = 3'd5
  } kind_e;

endpackage

FILE: rtl/core/exp_golomb_bit_reader.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader
// bitstream reader for header syntax: fixed reads, ue(v), se(v), byte skips
// ----------------------------------------------------------------------------
// start, push, skip and unused kinds give their result beat in the cycle after
//   acceptance; a read holds busy_o while it takes its bits (bits past the
//   loaded data too), fetches each byte not yet held, checks the count and
//   finishes, and its result beat follows
// throughput: one item at a time, busy_o stays high until the read finishes
// the single bit-take step and byte store read port set the pace
// reset: asynchronous active low, empties the store and rewinds the position;
//   the store needs no clearing pass, the fill count guards it
// the result beat is a one-cycle strobe on done_o; the receiver cannot stall
module exp_golomb_bit_reader
  import egbr_pkg::*;
#(
  parameter int STORE_BYTES = StoreBytesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command side
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               kind_i,
  input  logic [ByteW-1:0]         byte_value_i,
  input  logic [CntW-1:0]          bit_count_i,
  input  logic [ByteW-1:0]         skip_count_i,
  // result side
  output logic                     done_o,
  output logic signed [ValueW-1:0] value_o,
  output logic                     overrun_o,
  output logic [PosW-1:0]          bit_position_o
);

  // store address width, fill count width, width used to compare them
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LW = $clog2(STORE_BYTES + 1);
  localparam int CW = (LW > PosW) ? LW : PosW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREFIX,   // counting leading zeros of an exp-golomb code
    ST_SHIFT,    // shifting bits into the accumulator
    ST_FINISH    // forming the final value
  } state_e;

  typedef enum logic [1:0] {
    MODE_BITS,
    MODE_UE,
    MODE_SE
  } mode_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [LW-1:0]       loaded_q, loaded_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     zeros_q, zeros_d;
  logic                ovr_q, ovr_d;
  logic                cache_ok_q, cache_ok_d;
  logic [AW-1:0]       cache_idx_q, cache_idx_d;
  logic                done_q, done_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic                overrun_q, overrun_d;

  // byte store, one write port and one registered read port
  logic [ByteW-1:0]    store_mem [STORE_BYTES];
  logic [ByteW-1:0]    rdata_q;
  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  // bit take datapath
  logic [CW-1:0]       idx_ext;
  logic [CW-1:0]       loaded_ext;
  logic                in_range;
  logic                cache_hit;
  logic                need_bit;
  logic                bit_ok;
  logic                bit_val;
  logic                bit_adv;

  // finish and skip arithmetic
  logic [PosW:0]       skip_sum;
  logic [31:0]         code_k;
  logic [ValueW-1:0]   code_ext;
  logic [ValueW-1:0]   se_pos;
  logic [ValueW-1:0]   se_neg;

  logic                accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // byte index of the read position against the fill count
  assign idx_ext    = CW'(pos_q >> 3);
  assign loaded_ext = CW'(loaded_q);
  assign in_range   = idx_ext < loaded_ext;
  assign rd_addr    = idx_ext[AW-1:0];
  assign cache_hit  = cache_ok_q && (cache_idx_q == rd_addr);

  assign need_bit = (state_q == ST_PREFIX) || ((state_q == ST_SHIFT) && (cnt_q != '0));

  always_comb begin
    bit_ok  = 1'b0;
    bit_val = 1'b1;
    bit_adv = 1'b0;
    rd_en   = 1'b0;
    if (need_bit) begin
      if (!in_range) begin
        // past the loaded bytes: reads as one, position holds
        bit_ok  = 1'b1;
        bit_val = 1'b1;
      end else if (cache_hit) begin
        bit_ok  = 1'b1;
        bit_val = rdata_q[3'(~pos_q[2:0])];
        bit_adv = 1'b1;
      end else begin
        // fetch the byte, the take retries next cycle
        rd_en = 1'b1;
      end
    end
  end

  assign wr_en = accept && (kind_e'(kind_i) == KIND_PUSH) && (loaded_q < LW'(STORE_BYTES));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[loaded_q[AW-1:0]] <= byte_value_i;
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  assign skip_sum = (PosW+1)'(pos_q) + (PosW+1)'({skip_count_i, 3'b000});

  // saturated code when the prefix hit its limit, else accumulator minus one
  assign code_k   = (zeros_q == PrefixLimit) ? '1 : 32'(acc_q - ValueW'(1));
  assign code_ext = ValueW'(code_k);
  assign se_pos   = (code_ext + ValueW'(1)) >> 1;
  assign se_neg   = ValueW'(0) - (code_ext >> 1);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    loaded_d    = loaded_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    zeros_d     = zeros_q;
    ovr_d       = ovr_q;
    cache_ok_d  = cache_ok_q;
    cache_idx_d = cache_idx_q;
    done_d      = 1'b0;
    value_d     = value_q;
    overrun_d   = overrun_q;

    if (rd_en) begin
      cache_ok_d  = 1'b1;
      cache_idx_d = rd_addr;
    end
    if (bit_adv && (pos_q != '1)) begin
      pos_d = pos_q + PosW'(1);
    end
    if (bit_ok && !bit_adv) begin
      ovr_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ovr_d = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_START: begin
              loaded_d   = '0;
              pos_d      = '0;
              cache_ok_d = 1'b0;
              done_d     = 1'b1;
              value_d    = '0;
              overrun_d  = 1'b0;
            end
            KIND_PUSH: begin
              if (wr_en) begin
                loaded_d = loaded_q + LW'(1);
              end
              done_d    = 1'b1;
              value_d   = '0;
              overrun_d = 1'b0;
            end
            KIND_BITS: begin
              mode_d  = MODE_BITS;
              acc_d   = '0;
              cnt_d   = (bit_count_i > MaxBits) ? MaxBits : bit_count_i;
              state_d = ST_SHIFT;
            end
            KIND_UE, KIND_SE: begin
              mode_d  = (kind_e'(kind_i) == KIND_UE) ? MODE_UE : MODE_SE;
              zeros_d = '0;
              state_d = ST_PREFIX;
            end
            KIND_SKIP: begin
              pos_d     = skip_sum[PosW] ? '1 : skip_sum[PosW-1:0];
              done_d    = 1'b1;
              value_d   = '0;
              overrun_d = 1'b0;
            end
            default: begin
              done_d    = 1'b1;
              value_d   = '0;
              overrun_d = 1'b0;
            end
          endcase
        end
      end
      ST_PREFIX: begin
        if (bit_ok) begin
          // a one or the prefix limit ends the count; that bit is consumed
          if (bit_val || (zeros_q == PrefixLimit)) begin
            acc_d   = ValueW'(1);
            cnt_d   = zeros_q;
            state_d = ST_SHIFT;
          end else begin
            zeros_d = zeros_q + CntW'(1);
          end
        end
      end
      ST_SHIFT: begin
        if (cnt_q == '0) begin
          state_d = ST_FINISH;
        end else if (bit_ok) begin
          acc_d = {acc_q[ValueW-2:0], bit_val};
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_FINISH: begin
        case (mode_q)
          MODE_UE: value_d = code_ext;
          MODE_SE: value_d = code_k[0] ? se_pos : se_neg;
          default: value_d = acc_q;
        endcase
        overrun_d = ovr_q;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_BITS;
      pos_q       <= '0;
      loaded_q    <= '0;
      cnt_q       <= '0;
      zeros_q     <= '0;
      ovr_q       <= 1'b0;
      cache_ok_q  <= 1'b0;
      cache_idx_q <= '0;
      done_q      <= 1'b0;
      overrun_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      loaded_q    <= loaded_d;
      cnt_q       <= cnt_d;
      zeros_q     <= zeros_d;
      ovr_q       <= ovr_d;
      cache_ok_q  <= cache_ok_d;
      cache_idx_q <= cache_idx_d;
      done_q      <= done_d;
      overrun_q   <= overrun_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    value_q <= value_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign value_o        = $signed(value_q);
  assign overrun_o      = overrun_q;
  assign bit_position_o = pos_q;

endmodule

FILE: verif/tb_exp_golomb_bit_reader.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_reader
// self-checking bench for the exp-golomb bit reader: a table of directed
// commands, then random load-and-parse sessions, every result beat checked
// against a typed beat or a bit-level shadow of the reader's store and position
// ----------------------------------------------------------------------------
module tb_exp_golomb_bit_reader;
  import egbr_pkg::*;

  localparam int StoreDepth  = StoreBytesDef;
  localparam int PosMax      = (1 << PosW) - 1;
  localparam int RandomItems = 1000;
  localparam int DrainCycles = 100;
  localparam int DirRows     = 29;

  // kinds the block leaves undecoded
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  // one result beat as the reader presents it
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     overrun;
    logic [PosW-1:0]          bit_pos;
  } read_beat_t;

  // one line of the directed table; beat is only used where typed is set
  typedef struct packed {
    logic [2:0]       kind;
    logic [ByteW-1:0] byte_value;
    logic [CntW-1:0]  bit_count;
    logic [ByteW-1:0] skip_count;
    logic [8:0]       reps;
    logic             typed;
    read_beat_t       beat;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [2:0]               kind_i;
  logic [ByteW-1:0]         byte_value_i;
  logic [CntW-1:0]          bit_count_i;
  logic [ByteW-1:0]         skip_count_i;
  logic                     done_o;
  logic signed [ValueW-1:0] value_o;
  logic                     overrun_o;
  logic [PosW-1:0]          bit_position_o;

  // shadow copy of the reader state
  logic [ByteW-1:0] shadow_store [StoreDepth];
  int unsigned      shadow_fill    = 0;
  int unsigned      shadow_pos     = 0;
  logic             shadow_overrun = 1'b0;

  read_beat_t pending_beats [$];
  int         error_count   = 0;
  int         random_issued = 0;
  stim_row_t  dir_table [DirRows];

  exp_golomb_bit_reader i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .byte_value_i  (byte_value_i),
    .bit_count_i   (bit_count_i),
    .skip_count_i  (skip_count_i),
    .done_o        (done_o),
    .value_o       (value_o),
    .overrun_o     (overrun_o),
    .bit_position_o(bit_position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case a beat never shows up
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow bit reader
  // ---------------------------------------------------------------------------

  // one bit msb-first; past the loaded bytes it reads as 1 and stays put
  function automatic logic pull_bit();
    int unsigned idx;
    logic        b;
    idx = shadow_pos >> 3;
    if (idx >= shadow_fill) begin
      shadow_overrun = 1'b1;
      return 1'b1;
    end
    b = shadow_store[idx][7 - (shadow_pos & 7)];
    if (shadow_pos < PosMax) shadow_pos++;
    return b;
  endfunction

  function automatic logic [63:0] pull_bits(input int unsigned n);
    logic [63:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) acc = (acc << 1) | 64'(pull_bit());
    return acc;
  endfunction

  // prefix count stops at the limit, but the bit that ends it is still taken
  function automatic logic [63:0] pull_ue_code();
    int unsigned zeros;
    logic [63:0] code;
    zeros = 0;
    while (pull_bit() == 1'b0 && zeros < PrefixLimit) zeros++;
    code = pull_bits(zeros) + ((64'd1 << zeros) - 64'd1);
    if (code > 64'hFFFF_FFFF) code = 64'hFFFF_FFFF;
    return code;
  endfunction

  function automatic read_beat_t predict_beat(input logic [2:0] kind,
                                              input logic [ByteW-1:0] bval,
                                              input logic [CntW-1:0] nbits,
                                              input logic [ByteW-1:0] nskip);
    read_beat_t  beat;
    logic [63:0] code;
    int unsigned target;
    beat = '0;
    shadow_overrun = 1'b0;
    case (kind)
      KIND_START: begin
        shadow_fill = 0;
        shadow_pos  = 0;
      end
      KIND_PUSH: begin
        // a full store drops the byte
        if (shadow_fill < StoreDepth) begin
          shadow_store[shadow_fill] = bval;
          shadow_fill++;
        end
      end
      KIND_BITS: begin
        code = pull_bits((nbits > MaxBits) ? MaxBits : nbits);
        beat.value = code[ValueW-1:0];
      end
      KIND_UE: begin
        code = pull_ue_code();
        beat.value = code[ValueW-1:0];
      end
      KIND_SE: begin
        // odd codes map positive, even codes negative
        code = pull_ue_code();
        if (code[0]) code = (code + 64'd1) >> 1;
        else code = 64'd0 - (code >> 1);
        beat.value = code[ValueW-1:0];
      end
      KIND_SKIP: begin
        target = shadow_pos + 32'(nskip) * 8;
        shadow_pos = (target > PosMax) ? PosMax : target;
      end
      default: ;
    endcase
    beat.overrun = shadow_overrun;
    beat.bit_pos = shadow_pos[PosW-1:0];
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // random field and idle pickers
  // ---------------------------------------------------------------------------

  // heavy on zero and sparse bytes so exp-golomb prefixes get long
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 2) return '0;
    if (r == 2) return ByteW'(1) << $urandom_range(0, 7);
    if (r == 3) return ByteW'($urandom_range(0, 15));
    return ByteW'($urandom);
  endfunction

  // counts above 32 get clamped by the block, so they show up now and then
  function automatic logic [CntW-1:0] pick_count();
    if ($urandom_range(0, 7) == 0) return CntW'($urandom_range(33, 63));
    return CntW'($urandom_range(0, 32));
  endfunction

  function automatic logic [ByteW-1:0] pick_skip();
    if ($urandom_range(0, 9) == 0) return ByteW'($urandom_range(0, 255));
    return ByteW'($urandom_range(0, 4));
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // start_i stays high across back-to-back beats; it only drops for a gap
  task automatic send_item(input logic [2:0] kind, input logic [ByteW-1:0] bval,
                           input logic [CntW-1:0] nbits, input logic [ByteW-1:0] nskip,
                           input int idle, input bit typed, input read_beat_t typed_beat);
    read_beat_t predicted;
    if (idle > 0) begin
      start_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    kind_i       <= kind;
    byte_value_i <= bval;
    bit_count_i  <= nbits;
    skip_count_i <= nskip;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    // spare kinds and pushes into a full store do nothing, so do not count them
    if (!(kind == KindSpare6 || kind == KindSpare7 ||
          (kind == KIND_PUSH && shadow_fill >= StoreDepth)))
      random_issued++;
    predicted = predict_beat(kind, bval, nbits, nskip);
    pending_beats.push_back(typed ? typed_beat : predicted);
  endtask

  // every field random, including the ones this kind ignores
  task automatic send_random(input logic [2:0] kind, input bit calm);
    send_item(kind, pick_byte(), pick_count(), pick_skip(), idle_len(calm), 1'b0, '0);
  endtask

  // a load-then-parse session: start, a run of bytes, a run of header reads
  task automatic run_session();
    bit          calm;
    int unsigned n_bytes;
    int unsigned n_reads;
    int unsigned pick;
    calm = ($urandom_range(0, 3) == 0);
    // now and then keep appending to the previous stream instead
    if ($urandom_range(0, 7) != 0) send_random(KIND_START, calm);
    n_bytes = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 260)
                                           : $urandom_range(0, 12);
    repeat (n_bytes) send_random(KIND_PUSH, calm);
    n_reads = $urandom_range(1, 16);
    repeat (n_reads) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_random(KIND_BITS, calm);
      else if (pick < 60) send_random(KIND_UE, calm);
      else if (pick < 85) send_random(KIND_SE, calm);
      else if (pick < 92) send_random(KIND_SKIP, calm);
      else if (pick < 95) send_random($urandom_range(0, 1) ? KindSpare6 : KindSpare7, calm);
      else send_random(KIND_PUSH, calm);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: one beat per accepted command, in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    read_beat_t want;
    if (rst_ni && done_o) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing pending: value %0h", value_o);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, value_o);
          error_count++;
        end
        if (overrun_o !== want.overrun) begin
          $error("overrun: expected %0b, got %0b", want.overrun, overrun_o);
          error_count++;
        end
        if (bit_position_o !== want.bit_pos) begin
          $error("bit_position: expected %0d, got %0d", want.bit_pos, bit_position_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    kind_i       <= KIND_START;
    byte_value_i <= '0;
    bit_count_i  <= '0;
    skip_count_i <= '0;

    // directed commands; expected beats typed only where obvious
    dir_table = '{
      // reads straight out of reset hit an empty store
      '{KIND_BITS,  8'h00, 6'd1,  8'd0,   9'd1,   1'b1, '{33'd1, 1'b1, 12'd0}},
      '{KIND_UE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b1, '{33'd0, 1'b1, 12'd0}},
      '{KIND_START, 8'h00, 6'd0,  8'd0,   9'd1,   1'b1, '{33'd0, 1'b0, 12'd0}},
      // 32 zeros then all ones: longest prefix, saturated code
      '{KIND_PUSH,  8'h00, 6'd0,  8'd0,   9'd4,   1'b1, '{33'd0, 1'b0, 12'd0}},
      '{KIND_PUSH,  8'hFF, 6'd0,  8'd0,   9'd5,   1'b1, '{33'd0, 1'b0, 12'd0}},
      '{KIND_UE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b1, '{33'h0_FFFF_FFFF, 1'b0, 12'd65}},
      // count above 32 clamps, then runs off the end of the data
      '{KIND_BITS,  8'h00, 6'd63, 8'd0,   9'd1,   1'b1, '{33'h0_FFFF_FFFF, 1'b1, 12'd72}},
      '{KIND_SE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b1, '{33'd0, 1'b1, 12'd72}},
      // prefix ended by a zero at the limit, suffix overruns
      '{KIND_START, 8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_PUSH,  8'h00, 6'd0,  8'd0,   9'd5,   1'b0, '0},
      '{KIND_UE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      // short se codes of both signs
      '{KIND_START, 8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_PUSH,  8'h38, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_PUSH,  8'h30, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_PUSH,  8'hA5, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_SE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_SE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_BITS,  8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_BITS,  8'hFF, 6'd32, 8'hFF,  9'd1,   1'b0, '0},
      // undecoded kinds with every field bit set
      '{KindSpare6, 8'hFF, 6'h3F, 8'hFF,  9'd1,   1'b0, '0},
      '{KindSpare7, 8'hFF, 6'h3F, 8'hFF,  9'd1,   1'b0, '0},
      // skips far past the loaded bytes, then a read stuck there
      '{KIND_SKIP,  8'h00, 6'd0,  8'd255, 9'd1,   1'b0, '0},
      '{KIND_SKIP,  8'h00, 6'd0,  8'd255, 9'd1,   1'b0, '0},
      '{KIND_SKIP,  8'h00, 6'd0,  8'd1,   9'd1,   1'b0, '0},
      '{KIND_SKIP,  8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_BITS,  8'h00, 6'd5,  8'd0,   9'd1,   1'b0, '0},
      // fill the store and push once more into a full store
      '{KIND_START, 8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0},
      '{KIND_PUSH,  8'hC3, 6'd0,  8'd0,   9'd257, 1'b0, '0},
      '{KIND_UE,    8'h00, 6'd0,  8'd0,   9'd1,   1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      row = dir_table[r];
      for (int k = 0; k < row.reps; k++)
        send_item(row.kind, row.byte_value, row.bit_count, row.skip_count,
                  idle_len(1'b0), row.typed, row.beat);
    end

    random_issued = 0;
    while (random_issued < RandomItems) run_session();
    start_i <= 1'b0;

    // drain: every command gives exactly one beat
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/egbr_pkg.sv
rtl/core/exp_golomb_bit_reader.sv
verif/tb_exp_golomb_bit_reader.sv
